/* hw/rtl/tlctm_pkg.sv */
// Shared constants and types for the three-level cache tag model.
package tlctm_pkg;

    localparam int ADDR_BITS      = 48;
    localparam int LINE_LOG_BYTES = 6;
    localparam int TAG_BITS       = ADDR_BITS - LINE_LOG_BYTES;

    localparam int L1_LOG_BYTES = 15;
    localparam int L1_LOG_WAYS  = 3;
    localparam int L1_WAYS      = 1 << L1_LOG_WAYS;
    localparam int L1_SET_BITS  = L1_LOG_BYTES - LINE_LOG_BYTES - L1_LOG_WAYS;
    localparam int L1_SETS      = 1 << L1_SET_BITS;
    localparam int L1_ROW_BITS  = L1_WAYS * TAG_BITS;

    localparam int L2_LOG_BYTES = 18;
    localparam int L2_LOG_WAYS  = 3;
    localparam int L2_WAYS      = 1 << L2_LOG_WAYS;
    localparam int L2_SET_BITS  = L2_LOG_BYTES - LINE_LOG_BYTES - L2_LOG_WAYS;
    localparam int L2_SETS      = 1 << L2_SET_BITS;
    localparam int L2_ROW_BITS  = L2_WAYS * TAG_BITS;

    localparam int L3_LOG_BYTES = 21;
    localparam int L3_LOG_WAYS  = 4;
    localparam int L3_WAYS      = 1 << L3_LOG_WAYS;
    localparam int L3_SET_BITS  = L3_LOG_BYTES - LINE_LOG_BYTES - L3_LOG_WAYS;
    localparam int L3_SETS      = 1 << L3_SET_BITS;
    localparam int L3_ROW_BITS  = L3_WAYS * TAG_BITS;

    localparam int CLR_BITS_12 = (L1_SET_BITS > L2_SET_BITS) ? L1_SET_BITS : L2_SET_BITS;
    localparam int CLR_BITS    = (CLR_BITS_12 > L3_SET_BITS) ? CLR_BITS_12 : L3_SET_BITS;

    localparam int COUNT_BITS = 48;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam int IN_BITS        = ((ADDR_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 3 + 3 * COUNT_BITS;
    localparam int OUT_BITS       = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef logic [TAG_BITS-1:0]   tag_t;
    typedef logic [COUNT_BITS-1:0] count_t;

endpackage

/* hw/rtl/three_level_cache_tag_model_top.sv */
// Top level of the three-level cache tag model: tag RAMs, lookup, replace, counters.
// A request is taken in ST_IDLE and looked up in ST_LOOKUP, which registers its result
// and writes back missed set rows once the output is free; only then is a new one taken.
// Reset (rst_n low, asynchronous) clears pointers, miss counters and the config register,
// then a clearing pass over 2048 set rows zeroes all tag RAMs, one set row per cycle, with
// s_axis_tready low; configuration writes are taken during the pass.
module three_level_cache_tag_model_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic                          cfg_wdata,      // L3 index hashing enable
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [tlctm_pkg::IN_BITS-1:0] s_axis_tdata,   // address
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // l1_hit, l2_hit, l3_hit, l1_miss_total, l2_miss_total, l3_miss_total, zero pad
    output logic [tlctm_pkg::OUT_BITS-1:0] m_axis_tdata
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [tlctm_pkg::CLR_BITS-1:0] clr_reg;
    logic hashed_reg;

    logic [tlctm_pkg::ADDR_BITS-1:0] addr_in;
    tlctm_pkg::tag_t line_in;
    tlctm_pkg::tag_t line_reg;
    logic [tlctm_pkg::L1_SET_BITS-1:0] idx1_in, idx1_reg;
    logic [tlctm_pkg::L2_SET_BITS-1:0] idx2_in, idx2_reg;
    logic [tlctm_pkg::L3_SET_BITS-1:0] idx3_in, idx3_reg;

    logic [tlctm_pkg::L1_LOG_WAYS-1:0] vic1_reg;
    logic [tlctm_pkg::L2_LOG_WAYS-1:0] vic2_reg;
    logic [tlctm_pkg::L3_LOG_WAYS-1:0] vic3_reg;
    tlctm_pkg::count_t cnt1_reg, cnt2_reg, cnt3_reg;
    tlctm_pkg::count_t cnt1_next, cnt2_next, cnt3_next;

    logic [tlctm_pkg::L1_ROW_BITS-1:0] row1, new_row1, wdata1;
    logic [tlctm_pkg::L2_ROW_BITS-1:0] row2, new_row2, wdata2;
    logic [tlctm_pkg::L3_ROW_BITS-1:0] row3, new_row3, wdata3;
    logic [tlctm_pkg::L1_SET_BITS-1:0] waddr1;
    logic [tlctm_pkg::L2_SET_BITS-1:0] waddr2;
    logic [tlctm_pkg::L3_SET_BITS-1:0] waddr3;
    logic we1, we2, we3;
    logic hit1, hit2, hit3;

    logic accept;
    logic go;
    logic clearing;
    logic out_valid_reg;
    logic [tlctm_pkg::OUT_BITS-1:0] out_data_reg;

    assign clearing      = (state_reg == ST_CLEAR);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign go            = (state_reg == ST_LOOKUP) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign addr_in = s_axis_tdata[tlctm_pkg::ADDR_BITS-1:0];
    assign line_in = addr_in[tlctm_pkg::ADDR_BITS-1:tlctm_pkg::LINE_LOG_BYTES];
    assign idx1_in = line_in[tlctm_pkg::L1_SET_BITS-1:0];
    assign idx2_in = line_in[tlctm_pkg::L2_SET_BITS-1:0];
    assign idx3_in = line_in[tlctm_pkg::L3_SET_BITS-1:0]
                   ^ (addr_in[tlctm_pkg::L3_LOG_BYTES +: tlctm_pkg::L3_SET_BITS]
                      & {tlctm_pkg::L3_SET_BITS{hashed_reg}});

    // Compare all ways and build the row with the victim way replaced.
    always_comb
    begin
        hit1     = 1'b0;
        new_row1 = row1;
        for (int w = 0; w < tlctm_pkg::L1_WAYS; w++)
        begin
            if (row1[w*tlctm_pkg::TAG_BITS +: tlctm_pkg::TAG_BITS] == line_reg)
            begin
                hit1 = 1'b1;
            end
            if (tlctm_pkg::L1_LOG_WAYS'(w) == vic1_reg)
            begin
                new_row1[w*tlctm_pkg::TAG_BITS +: tlctm_pkg::TAG_BITS] = line_reg;
            end
        end
    end

    always_comb
    begin
        hit2     = 1'b0;
        new_row2 = row2;
        for (int w = 0; w < tlctm_pkg::L2_WAYS; w++)
        begin
            if (row2[w*tlctm_pkg::TAG_BITS +: tlctm_pkg::TAG_BITS] == line_reg)
            begin
                hit2 = 1'b1;
            end
            if (tlctm_pkg::L2_LOG_WAYS'(w) == vic2_reg)
            begin
                new_row2[w*tlctm_pkg::TAG_BITS +: tlctm_pkg::TAG_BITS] = line_reg;
            end
        end
    end

    always_comb
    begin
        hit3     = 1'b0;
        new_row3 = row3;
        for (int w = 0; w < tlctm_pkg::L3_WAYS; w++)
        begin
            if (row3[w*tlctm_pkg::TAG_BITS +: tlctm_pkg::TAG_BITS] == line_reg)
            begin
                hit3 = 1'b1;
            end
            if (tlctm_pkg::L3_LOG_WAYS'(w) == vic3_reg)
            begin
                new_row3[w*tlctm_pkg::TAG_BITS +: tlctm_pkg::TAG_BITS] = line_reg;
            end
        end
    end

    // Saturate the miss counters.
    always_comb
    begin
        cnt1_next = cnt1_reg;
        cnt2_next = cnt2_reg;
        cnt3_next = cnt3_reg;
        if (!hit1 && (cnt1_reg != tlctm_pkg::COUNT_MAX))
        begin
            cnt1_next = cnt1_reg + 1'b1;
        end
        if (!hit2 && (cnt2_reg != tlctm_pkg::COUNT_MAX))
        begin
            cnt2_next = cnt2_reg + 1'b1;
        end
        if (!hit3 && (cnt3_reg != tlctm_pkg::COUNT_MAX))
        begin
            cnt3_next = cnt3_reg + 1'b1;
        end
    end

    always_comb
    begin
        we1    = go && !hit1;
        we2    = go && !hit2;
        we3    = go && !hit3;
        waddr1 = idx1_reg;
        waddr2 = idx2_reg;
        waddr3 = idx3_reg;
        wdata1 = new_row1;
        wdata2 = new_row2;
        wdata3 = new_row3;
        if (clearing)
        begin
            we1    = ({1'b0, clr_reg} < (tlctm_pkg::CLR_BITS + 1)'(tlctm_pkg::L1_SETS));
            we2    = ({1'b0, clr_reg} < (tlctm_pkg::CLR_BITS + 1)'(tlctm_pkg::L2_SETS));
            we3    = ({1'b0, clr_reg} < (tlctm_pkg::CLR_BITS + 1)'(tlctm_pkg::L3_SETS));
            waddr1 = clr_reg[tlctm_pkg::L1_SET_BITS-1:0];
            waddr2 = clr_reg[tlctm_pkg::L2_SET_BITS-1:0];
            waddr3 = clr_reg[tlctm_pkg::L3_SET_BITS-1:0];
            wdata1 = '0;
            wdata2 = '0;
            wdata3 = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == {tlctm_pkg::CLR_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            hashed_reg    <= 1'b0;
            vic1_reg      <= '0;
            vic2_reg      <= '0;
            vic3_reg      <= '0;
            cnt1_reg      <= '0;
            cnt2_reg      <= '0;
            cnt3_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_wen)
            begin
                hashed_reg <= cfg_wdata;
            end
            if (go)
            begin
                out_valid_reg <= 1'b1;
                cnt1_reg      <= cnt1_next;
                cnt2_reg      <= cnt2_next;
                cnt3_reg      <= cnt3_next;
                if (!hit1)
                begin
                    vic1_reg <= vic1_reg + 1'b1;
                end
                if (!hit2)
                begin
                    vic2_reg <= vic2_reg + 1'b1;
                end
                if (!hit3)
                begin
                    vic3_reg <= vic3_reg + 1'b1;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_reg <= line_in;
            idx1_reg <= idx1_in;
            idx2_reg <= idx2_in;
            idx3_reg <= idx3_in;
        end
        if (go)
        begin
            out_data_reg <= {{(tlctm_pkg::OUT_BITS - tlctm_pkg::OUT_FIELD_BITS){1'b0}},
                             cnt3_next, cnt2_next, cnt1_next, hit3, hit2, hit1};
        end
    end

    tlctm_ram #(
        .DEPTH (tlctm_pkg::L1_SETS),
        .WIDTH (tlctm_pkg::L1_ROW_BITS)
    ) u_l1_ram (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr1),
        .wdata (wdata1),
        .re    (accept),
        .raddr (idx1_in),
        .rdata (row1)
    );

    tlctm_ram #(
        .DEPTH (tlctm_pkg::L2_SETS),
        .WIDTH (tlctm_pkg::L2_ROW_BITS)
    ) u_l2_ram (
        .clk   (clk),
        .we    (we2),
        .waddr (waddr2),
        .wdata (wdata2),
        .re    (accept),
        .raddr (idx2_in),
        .rdata (row2)
    );

    tlctm_ram #(
        .DEPTH (tlctm_pkg::L3_SETS),
        .WIDTH (tlctm_pkg::L3_ROW_BITS)
    ) u_l3_ram (
        .clk   (clk),
        .we    (we3),
        .waddr (waddr3),
        .wdata (wdata3),
        .re    (accept),
        .raddr (idx3_in),
        .rdata (row3)
    );

endmodule

/* hw/rtl/tlctm_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
module tlctm_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* tb/tb_three_level_cache_tag_model_top.sv */
// Testbench for the three-level cache tag model: random-stall stream traffic and tag predictor.
`timescale 1ns / 1ps

module tb_three_level_cache_tag_model_top;
    import tlctm_pkg::*;

    localparam int L1_LEVEL    = 0;
    localparam int L2_LEVEL    = 1;
    localparam int L3_LEVEL    = 2;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_ITEMS = 125;

    typedef struct {
        bit     l1_hit;
        bit     l2_hit;
        bit     l3_hit;
        count_t l1_miss;
        count_t l2_miss;
        count_t l3_miss;
    } lookup_result_t;

    class tag_lookup_checker;
        bit [TAG_BITS-1:0]   line_tags [3][L3_SETS * L3_WAYS];
        int unsigned         victim_way [3];
        bit [COUNT_BITS-1:0] miss_count [3];
        bit                  l3_hash_on;
        lookup_result_t      pending_lookups [$];
        int unsigned         mismatches;

        function bit probe_level(int lvl, bit [ADDR_BITS-1:0] set_sel, bit [TAG_BITS-1:0] line);
            int log_ways;
            int sets;
            int base;
            log_ways = (lvl == L3_LEVEL) ? L3_LOG_WAYS :
                       (lvl == L2_LEVEL) ? L2_LOG_WAYS : L1_LOG_WAYS;
            sets     = (lvl == L3_LEVEL) ? L3_SETS :
                       (lvl == L2_LEVEL) ? L2_SETS : L1_SETS;
            base     = int'(set_sel % sets) << log_ways;
            for (int w = 0; w < (1 << log_ways); w++)
            begin
                if (line_tags[lvl][base + w] == line)
                    return 1'b1;
            end
            line_tags[lvl][base + victim_way[lvl]] = line;
            victim_way[lvl] = (victim_way[lvl] + 1) % (1 << log_ways);
            if (miss_count[lvl] != COUNT_MAX)
                miss_count[lvl]++;
            return 1'b0;
        endfunction

        function void note_access(bit [ADDR_BITS-1:0] addr);
            lookup_result_t     r;
            bit [TAG_BITS-1:0]  line;
            bit [ADDR_BITS-1:0] l3_sel;
            line   = TAG_BITS'(addr >> LINE_LOG_BYTES);
            l3_sel = ADDR_BITS'(line);
            if (l3_hash_on)
                l3_sel = ADDR_BITS'(line) ^ (addr >> L3_LOG_BYTES);
            r.l1_hit  = probe_level(L1_LEVEL, ADDR_BITS'(line), line);
            r.l2_hit  = probe_level(L2_LEVEL, ADDR_BITS'(line), line);
            r.l3_hit  = probe_level(L3_LEVEL, l3_sel, line);
            r.l1_miss = miss_count[L1_LEVEL];
            r.l2_miss = miss_count[L2_LEVEL];
            r.l3_miss = miss_count[L3_LEVEL];
            pending_lookups.push_back(r);
        endfunction

        function void compare_field(string field, bit [COUNT_BITS-1:0] want,
                                    logic [COUNT_BITS-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_lookup(logic [OUT_BITS-1:0] d);
            lookup_result_t want;
            if (pending_lookups.size() == 0)
            begin
                $error("result with no request outstanding: %h", d);
                mismatches++;
                return;
            end
            want = pending_lookups.pop_front();
            compare_field("l1_hit", COUNT_BITS'(want.l1_hit), COUNT_BITS'(d[0]));
            compare_field("l2_hit", COUNT_BITS'(want.l2_hit), COUNT_BITS'(d[1]));
            compare_field("l3_hit", COUNT_BITS'(want.l3_hit), COUNT_BITS'(d[2]));
            compare_field("l1_miss_total", want.l1_miss, d[3 +: COUNT_BITS]);
            compare_field("l2_miss_total", want.l2_miss, d[3 + COUNT_BITS +: COUNT_BITS]);
            compare_field("l3_miss_total", want.l3_miss, d[3 + 2 * COUNT_BITS +: COUNT_BITS]);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wen = 1'b0;
    logic                cfg_wdata = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;

    tag_lookup_checker  tag_check = new();
    bit [ADDR_BITS-1:0] recent_addrs [$];
    bit [ADDR_BITS-1:0] page_bases [4];
    bit [ADDR_BITS-1:0] conflict_low;
    int                 send_calm;
    int                 recv_calm;
    int unsigned        stall_cycles;

    bit [ADDR_BITS-1:0] directed_plain [$] = '{
        48'h0000_0000_0000, 48'h0000_0000_003F, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0040,
        48'h0000_0002_0000, 48'h0000_0004_0000, 48'h0000_0006_0000, 48'h0000_0008_0000,
        48'h0000_000A_0000, 48'h0000_000C_0000, 48'h0000_000E_0000, 48'h0000_0010_0000,
        48'h0000_0012_0000, 48'h0000_0000_0000, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFC0
    };
    bit [ADDR_BITS-1:0] directed_hashed [$] = '{
        48'h0000_0020_0040, 48'h0000_0040_0040, 48'h0000_0020_0040,
        48'hFFFF_FFE0_0000, 48'h0000_0000_0000
    };

    three_level_cache_tag_model_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    function automatic int pick_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic bit [ADDR_BITS-1:0] pick_address();
        int unsigned        roll;
        bit [ADDR_BITS-1:0] a;
        roll = $urandom_range(0, 99);
        if (roll < 40 && recent_addrs.size() != 0)
            a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)]
                ^ ADDR_BITS'($urandom_range(0, 63));
        else if (roll < 70)
            a = page_bases[$urandom_range(0, 3)] | ADDR_BITS'($urandom_range(0, 16'hFFFF));
        else if (roll < 85)
            a = (ADDR_BITS'($urandom_range(0, 31)) << $urandom_range(17, 21)) | conflict_low;
        else
            a = ADDR_BITS'({$urandom(), $urandom()});
        return a;
    endfunction

    task automatic send_access(input bit [ADDR_BITS-1:0] addr);
        int gap;
        gap = pick_wait(send_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_BITS'(addr);
        do
            @(posedge clk);
        while (!s_axis_tready);
        tag_check.note_access(addr);
    endtask

    task automatic drain_lookups();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (tag_check.pending_lookups.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_l3_hashing(input bit on);
        repeat (4) @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= on;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        tag_check.l3_hash_on = on;
    endtask

    initial
    begin
        int gap;
        recv_calm = 0;
        forever
        begin
            gap = pick_wait(recv_calm);
            @(negedge clk);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);
            tag_check.check_lookup(m_axis_tdata);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1) || (m_axis_tready && m_axis_tvalid === 1'b1))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        bit [ADDR_BITS-1:0] a;
        send_calm    = 0;
        stall_cycles = 0;
        foreach (page_bases[p])
            page_bases[p] = ADDR_BITS'({$urandom(), $urandom()}) & ~ADDR_BITS'(16'hFFFF);
        conflict_low = ADDR_BITS'($urandom_range(0, 17'h1FFFF));
        @(posedge rst_n);
        set_l3_hashing(1'b0);
        foreach (directed_plain[k])
            send_access(directed_plain[k]);
        drain_lookups();
        set_l3_hashing(1'b1);
        foreach (directed_hashed[k])
            send_access(directed_hashed[k]);
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase > 0)
            begin
                drain_lookups();
                set_l3_hashing(phase % 2 == 0);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 0 && n == 60)
                    drain_lookups();
                a = pick_address();
                send_access(a);
                recent_addrs.push_back(a);
                if (recent_addrs.size() > 64)
                    void'(recent_addrs.pop_front());
            end
        end
        drain_lookups();
        repeat (10) @(posedge clk);
        if (tag_check.mismatches == 0 && tag_check.pending_lookups.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
